// ----- hw/rtl/tcw_pkg.sv -----
// shared types, character codes and action codes for the text console writer
// no dependencies; imported by tcw_ctrl and text_console_writer_unit
package tcw_pkg;

  localparam int DEF_NUM_COLS = 80;
  localparam int DEF_NUM_ROWS = 25;

  localparam int POS_W    = 11;
  localparam int TAB_STOP = 4;
  localparam int TAB_W    = $clog2(TAB_STOP);
  localparam int EMIT_W   = $clog2(TAB_STOP + 1);

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0] DEFAULT_ATTR_RST = 8'd7;

  localparam logic [2:0] ACT_PUT_CURSOR = 3'd0;
  localparam logic [2:0] ACT_PUT_AT     = 3'd1;
  localparam logic [2:0] ACT_CLEAR      = 3'd2;
  localparam logic [2:0] ACT_SET_ATTR   = 3'd3;
  localparam logic [2:0] ACT_READ       = 3'd4;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] char_code;
    logic [4:0] target_row;
    logic [6:0] target_col;
    logic [7:0] new_attr;
  } tcw_item_t;

  typedef struct packed {
    logic [POS_W-1:0] cursor_pos;
    logic [7:0]       cell_char;
    logic [7:0]       cell_attr;
    logic             out_of_range;
  } tcw_result_t;

endpackage

// ----- hw/rtl/text_console_writer_unit.sv -----
// Text console writer. Holds a NUM_ROWS x NUM_COLS store of 16-bit text cells
// (character in bits 7:0, attribute in 15:8) in one synchronous ram, plus the
// cursor and the current attribute. Items are taken one at a time: in_ready is
// high only while the sequencer is idle. After decode, an ordinary character
// takes one emit step and a cell read takes a read step before finish;
// carriage return, line feed without scroll, set attribute, positioned write
// and the unused action codes go straight to finish; a tab emits its n
// spaces (n = 1 to 4) one per emit step. Every cell is written through the
// single ram write port, one at a time. A scroll (line feed or wrap on the last
// row) adds a pre-read step and a sweep over every cell for the row-up copy and
// bottom-row fill, and a clear sweeps every cell for its fill. A result that
// the consumer has not taken holds the sequencer in its finish state until the
// result register frees up. The store holds garbage after reset until cleared
// or written; reading an unwritten cell gives an unspecified value.
// default_attr is written through cfg_we/cfg_wdata and only takes effect at
// the next clear or scroll fill.
// uses tcw_pkg, tcw_ram and tcw_ctrl
module text_console_writer_unit #(
  parameter int NUM_COLS = tcw_pkg::DEF_NUM_COLS,
  parameter int NUM_ROWS = tcw_pkg::DEF_NUM_ROWS
) (
  input  logic       clk,
  input  logic       rst,
  // input item channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] action,
  input  logic [7:0] char_code,
  input  logic [4:0] target_row,
  input  logic [6:0] target_col,
  input  logic [7:0] new_attr,
  // result item channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [tcw_pkg::POS_W-1:0] cursor_pos,
  output logic [7:0] cell_char,
  output logic [7:0] cell_attr,
  output logic       out_of_range,
  // default attribute register
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  import tcw_pkg::*;

  localparam int CELLS  = NUM_COLS * NUM_ROWS;
  localparam int ADDR_W = $clog2(CELLS);

  logic [7:0]        default_attr;
  tcw_item_t         item;
  tcw_result_t       res;
  logic              res_done;
  logic              out_free;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [15:0]       ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [15:0]       ram_rdata;

  // config register, reset to the standard light-grey-on-black attribute
  always_ff @(posedge clk) begin
    if (rst) begin
      default_attr <= DEFAULT_ATTR_RST;
    end else if (cfg_we) begin
      default_attr <= cfg_wdata;
    end
  end

  assign item.action     = action;
  assign item.char_code  = char_code;
  assign item.target_row = target_row;
  assign item.target_col = target_col;
  assign item.new_attr   = new_attr;

  // the result register can be refilled in the cycle it is taken
  assign out_free = !out_valid || out_ready;

  tcw_ctrl #(
    .NUM_COLS (NUM_COLS),
    .NUM_ROWS (NUM_ROWS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (in_valid),
    .item_ready   (in_ready),
    .item         (item),
    .default_attr (default_attr),
    .out_free     (out_free),
    .res_done     (res_done),
    .res          (res),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

  // cell store
  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result register: parts the sequencer from the consumer, so the next item
  // can be taken while this one waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_done) begin
      cursor_pos   <= res.cursor_pos;
      cell_char    <= res.cell_char;
      cell_attr    <= res.cell_attr;
      out_of_range <= res.out_of_range;
    end
  end

  // one item in flight: ready drops right after an item is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in progress");

  // a finished result never overwrites one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_done |-> !out_valid || out_ready)
    else $error("result register overwritten");

  // an out-of-range access never reports cell contents
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> cell_char == 8'd0 && cell_attr == 8'd0)
    else $error("out-of-range result carries cell data");

  // the scroll copy never writes the cell it is reading in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("same-cycle read and write of one cell");

endmodule

// ----- hw/rtl/tcw_ram.sv -----
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/tcw_ctrl.sv -----
// sequencer for the text console writer: cursor, current attribute and all
// cell store traffic (writes, reads, scroll copy, clear sweep); uses tcw_pkg
module tcw_ctrl #(
  parameter int NUM_COLS = tcw_pkg::DEF_NUM_COLS,
  parameter int NUM_ROWS = tcw_pkg::DEF_NUM_ROWS,
  localparam int CELLS  = NUM_COLS * NUM_ROWS,
  localparam int ADDR_W = $clog2(CELLS)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  tcw_pkg::tcw_item_t  item,
  input  logic [7:0]          default_attr,
  input  logic                out_free,
  output logic                res_done,
  output tcw_pkg::tcw_result_t res,
  output logic                ram_we,
  output logic [ADDR_W-1:0]   ram_waddr,
  output logic [15:0]         ram_wdata,
  output logic                ram_re,
  output logic [ADDR_W-1:0]   ram_raddr,
  input  logic [15:0]         ram_rdata
);

  import tcw_pkg::*;

  localparam int ROW_W = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int COL_W = $clog2(NUM_COLS);
  localparam int KEEP  = (NUM_ROWS - 1) * NUM_COLS;

  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(NUM_ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(NUM_COLS - 1);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);

  localparam logic [2:0] ST_IDLE       = 3'd0;
  localparam logic [2:0] ST_DECODE     = 3'd1;
  localparam logic [2:0] ST_EMIT       = 3'd2;
  localparam logic [2:0] ST_SCROLL_PRE = 3'd3;
  localparam logic [2:0] ST_SCROLL     = 3'd4;
  localparam logic [2:0] ST_CLEAR      = 3'd5;
  localparam logic [2:0] ST_READ       = 3'd6;
  localparam logic [2:0] ST_FINISH     = 3'd7;

  logic [2:0]        state;
  tcw_item_t         itm;
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;
  logic [7:0]        cur_attr;
  logic [EMIT_W-1:0] emit_cnt;
  logic [7:0]        emit_chr;
  logic [ADDR_W-1:0] wcnt;
  logic [7:0]        res_char;
  logic [7:0]        res_attr;
  logic              res_oor;

  logic              in_screen;
  logic [ADDR_W-1:0] tgt_addr;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W:0]   scroll_rd;
  logic [EMIT_W-1:0] tab_fill;
  logic [15:0]       blank;

  assign in_screen = (32'(itm.target_row) < NUM_ROWS) && (32'(itm.target_col) < NUM_COLS);
  assign tgt_addr  = ADDR_W'(itm.target_row) * ADDR_W'(NUM_COLS) + ADDR_W'(itm.target_col);
  assign cur_addr  = ADDR_W'(cur_row) * ADDR_W'(NUM_COLS) + ADDR_W'(cur_col);
  // source cell read one step ahead of the write
  assign scroll_rd = (ADDR_W+1)'(wcnt) + (ADDR_W+1)'(NUM_COLS + 1);
  assign tab_fill  = EMIT_W'(TAB_STOP) - EMIT_W'(cur_col[TAB_W-1:0]);
  assign blank     = {default_attr, CH_SPACE};

  assign item_ready = (state == ST_IDLE);
  assign res_done   = (state == ST_FINISH) && out_free;

  assign res.cursor_pos   = POS_W'(cur_addr);
  assign res.cell_char    = res_char;
  assign res.cell_attr    = res_attr;
  assign res.out_of_range = res_oor;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_addr;
    ram_wdata = {cur_attr, emit_chr};
    ram_re    = 1'b0;
    ram_raddr = tgt_addr;
    case (state)
      ST_DECODE: begin
        if (itm.action == ACT_PUT_AT && in_screen) begin
          ram_we    = 1'b1;
          ram_waddr = tgt_addr;
          ram_wdata = {cur_attr, itm.char_code};
        end
        if (itm.action == ACT_READ && in_screen) begin
          ram_re = 1'b1;
        end
      end
      ST_EMIT: begin
        ram_we = 1'b1;
      end
      ST_SCROLL_PRE: begin
        ram_re    = 1'b1;
        ram_raddr = ADDR_W'(NUM_COLS);
      end
      ST_SCROLL: begin
        ram_we    = 1'b1;
        ram_waddr = wcnt;
        ram_wdata = (32'(wcnt) < KEEP) ? ram_rdata : blank;
        ram_re    = (32'(scroll_rd) < CELLS);
        ram_raddr = ADDR_W'(scroll_rd);
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = wcnt;
        ram_wdata = blank;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cur_row  <= '0;
      cur_col  <= '0;
      cur_attr <= DEFAULT_ATTR_RST;
      emit_cnt <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            itm      <= item;
            res_char <= '0;
            res_attr <= '0;
            res_oor  <= 1'b0;
            state    <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          state <= ST_FINISH;
          case (itm.action)
            ACT_PUT_CURSOR: begin
              if (itm.char_code == CH_LF) begin
                cur_col  <= '0;
                emit_cnt <= '0;
                if (cur_row == LAST_ROW) begin
                  state <= ST_SCROLL_PRE;
                end else begin
                  cur_row <= cur_row + 1'b1;
                end
              end else if (itm.char_code == CH_CR) begin
                cur_col <= '0;
              end else if (itm.char_code == CH_TAB) begin
                emit_cnt <= tab_fill;
                emit_chr <= CH_SPACE;
                state    <= ST_EMIT;
              end else begin
                emit_cnt <= EMIT_W'(1);
                emit_chr <= itm.char_code;
                state    <= ST_EMIT;
              end
            end
            ACT_PUT_AT: begin
              res_oor <= !in_screen;
            end
            ACT_CLEAR: begin
              wcnt  <= '0;
              state <= ST_CLEAR;
            end
            ACT_SET_ATTR: begin
              cur_attr <= itm.new_attr;
            end
            ACT_READ: begin
              res_oor <= !in_screen;
              if (in_screen) begin
                state <= ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
        ST_EMIT: begin
          emit_cnt <= emit_cnt - 1'b1;
          state    <= (emit_cnt == EMIT_W'(1)) ? ST_FINISH : ST_EMIT;
          if (cur_col == LAST_COL) begin
            cur_col <= '0;
            if (cur_row == LAST_ROW) begin
              state <= ST_SCROLL_PRE;
            end else begin
              cur_row <= cur_row + 1'b1;
            end
          end else begin
            cur_col <= cur_col + 1'b1;
          end
        end
        ST_SCROLL_PRE: begin
          wcnt  <= '0;
          state <= ST_SCROLL;
        end
        ST_SCROLL: begin
          if (wcnt == LAST_CELL) begin
            cur_row <= LAST_ROW;
            cur_col <= '0;
            state   <= (emit_cnt != '0) ? ST_EMIT : ST_FINISH;
          end else begin
            wcnt <= wcnt + 1'b1;
          end
        end
        ST_CLEAR: begin
          if (wcnt == LAST_CELL) begin
            cur_row  <= '0;
            cur_col  <= '0;
            cur_attr <= default_attr;
            state    <= ST_FINISH;
          end else begin
            wcnt <= wcnt + 1'b1;
          end
        end
        ST_READ: begin
          res_char <= ram_rdata[7:0];
          res_attr <= ram_rdata[15:8];
          state    <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// self-checking bench for text_console_writer_unit: scoreboard class with a screen predictor
// depends on tcw_pkg and text_console_writer_unit
module testbench;
  import tcw_pkg::*;

  localparam int COLS         = DEF_NUM_COLS;
  localparam int ROWS         = DEF_NUM_ROWS;
  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 12;
  // a clear or a scroll sweeps the whole store, so allow that plus slack
  localparam int SETTLE_CYCLES = ROWS * COLS + 16;
  localparam int QUIET_LIMIT   = 10 * SETTLE_CYCLES;
  localparam int MAX_REPORTS   = 60;

  // action codes the block ignores
  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  // screen predictor and queue of awaited results
  class screen_scoreboard;
    bit [15:0]    cells [ROWS*COLS];
    int unsigned  cur_row;
    int unsigned  cur_col;
    logic [7:0]   cur_attr;
    logic [7:0]   dflt_attr;
    tcw_result_t  replies_due[$];
    int           errors;
    int           seen;

    function new();
      cells     = '{default: '0};
      cur_row   = 0;
      cur_col   = 0;
      dflt_attr = DEFAULT_ATTR_RST;
      cur_attr  = DEFAULT_ATTR_RST;
      errors    = 0;
      seen      = 0;
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    // register write only; the current attribute waits for a clear
    function void set_default(logic [7:0] attr);
      dflt_attr = attr;
    endfunction

    function void scroll_if_past_end();
      if (cur_row < ROWS) return;
      for (int i = 0; i < (ROWS - 1) * COLS; i++) cells[i] = cells[i + COLS];
      for (int c = 0; c < COLS; c++) cells[(ROWS - 1) * COLS + c] = {dflt_attr, CH_SPACE};
      cur_row = ROWS - 1;
      cur_col = 0;
    endfunction

    function void emit_char(logic [7:0] ch);
      cells[cur_row * COLS + cur_col] = {cur_attr, ch};
      cur_col++;
      if (cur_col >= COLS) begin
        cur_col = 0;
        cur_row++;
        scroll_if_past_end();
      end
    endfunction

    // advance the screen by one accepted item and queue its result
    function void note_item(tcw_item_t it);
      tcw_result_t r;
      int unsigned spaces;
      int unsigned cell_idx;
      bit on_screen;
      r         = '0;
      on_screen = (it.target_row < ROWS) && (it.target_col < COLS);
      cell_idx  = int'(it.target_row) * COLS + int'(it.target_col);
      case (it.action)
        ACT_PUT_CURSOR: begin
          if (it.char_code == CH_LF) begin
            cur_col = 0;
            cur_row++;
            scroll_if_past_end();
          end else if (it.char_code == CH_CR) begin
            cur_col = 0;
          end else if (it.char_code == CH_TAB) begin
            spaces = TAB_STOP - (cur_col % TAB_STOP);
            repeat (spaces) emit_char(CH_SPACE);
          end else begin
            emit_char(it.char_code);
          end
        end
        ACT_PUT_AT: begin
          if (on_screen) cells[cell_idx] = {cur_attr, it.char_code};
          else r.out_of_range = 1'b1;
        end
        ACT_CLEAR: begin
          foreach (cells[i]) cells[i] = {dflt_attr, CH_SPACE};
          cur_row  = 0;
          cur_col  = 0;
          cur_attr = dflt_attr;
        end
        ACT_SET_ATTR: cur_attr = it.new_attr;
        ACT_READ: begin
          if (on_screen) begin
            r.cell_char = cells[cell_idx][7:0];
            r.cell_attr = cells[cell_idx][15:8];
          end else begin
            r.out_of_range = 1'b1;
          end
        end
        default: ;
      endcase
      r.cursor_pos = POS_W'(cur_row * COLS + cur_col);
      replies_due.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("[%0t] %s", $realtime, msg);
    endtask

    task check_result(tcw_result_t got);
      tcw_result_t want;
      seen++;
      if (replies_due.size() == 0) begin
        report($sformatf("result %0d arrived with nothing awaited", seen));
        return;
      end
      want = replies_due.pop_front();
      if (got.cursor_pos !== want.cursor_pos)
        report($sformatf("result %0d cursor_pos got %0d want %0d",
                         seen, got.cursor_pos, want.cursor_pos));
      if (got.cell_char !== want.cell_char)
        report($sformatf("result %0d cell_char got %h want %h",
                         seen, got.cell_char, want.cell_char));
      if (got.cell_attr !== want.cell_attr)
        report($sformatf("result %0d cell_attr got %h want %h",
                         seen, got.cell_attr, want.cell_attr));
      if (got.out_of_range !== want.out_of_range)
        report($sformatf("result %0d out_of_range got %b want %b",
                         seen, got.out_of_range, want.out_of_range));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  logic              in_valid;
  logic              in_ready;
  logic [2:0]        action;
  logic [7:0]        char_code;
  logic [4:0]        target_row;
  logic [6:0]        target_col;
  logic [7:0]        new_attr;
  logic              out_valid;
  logic              out_ready;
  logic [POS_W-1:0]  cursor_pos;
  logic [7:0]        cell_char;
  logic [7:0]        cell_attr;
  logic              out_of_range;
  logic              cfg_we;
  logic [7:0]        cfg_wdata;

  // idling odds in percent, set per phase
  int idle_pct  = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  screen_scoreboard sb;

  always #(CLK_PERIOD / 2) clk = ~clk;

  text_console_writer_unit #(
    .NUM_COLS(COLS),
    .NUM_ROWS(ROWS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .char_code(char_code),
    .target_row(target_row),
    .target_col(target_col),
    .new_attr(new_attr),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cursor_pos(cursor_pos),
    .cell_char(cell_char),
    .cell_attr(cell_attr),
    .out_of_range(out_of_range),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // receiver: random back-pressure at the phase's stall rate
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // monitor: note the accepted item first, then check any result at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.note_item('{action, char_code, target_row, target_col, new_attr});
      if (out_valid && out_ready)
        sb.check_result('{cursor_pos, cell_char, cell_attr, out_of_range});
    end
  end

  // watchdog: too long without any handshake means the block is hung
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("text_console_writer_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic tcw_item_t mk(logic [2:0] act, logic [7:0] ch, logic [4:0] row,
                                   logic [6:0] col, logic [7:0] attr);
    return '{act, ch, row, col, attr};
  endfunction

  // one random item; lf_pct is the share of line feeds among cursor puts
  function automatic tcw_item_t random_item(int lf_pct);
    tcw_item_t it;
    int pick;
    it.action     = ACT_PUT_CURSOR;
    it.char_code  = 8'($urandom);
    it.target_row = 5'($urandom);
    it.target_col = 7'($urandom);
    it.new_attr   = 8'($urandom);
    // most positioned items land on the screen, the rest anywhere
    if ($urandom_range(3) != 0) begin
      it.target_row = 5'($urandom_range(ROWS - 1));
      it.target_col = 7'($urandom_range(COLS - 1));
    end
    pick = $urandom_range(999);
    if (pick < 550) begin
      pick = $urandom_range(99);
      if (pick < lf_pct) it.char_code = CH_LF;
      else if (pick < lf_pct + 5) it.char_code = CH_CR;
      else if (pick < lf_pct + 13) it.char_code = CH_TAB;
      else if (pick < lf_pct + 60) it.char_code = 8'($urandom_range(8'h7E, 8'h20));
    end else if (pick < 700) begin
      it.action = ACT_PUT_AT;
    end else if (pick < 760) begin
      it.action = ACT_SET_ATTR;
    end else if (pick < 960) begin
      it.action = ACT_READ;
    end else if (pick < 966) begin
      it.action = ACT_CLEAR;
    end else begin
      it.action = 3'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
    end
    return it;
  endfunction

  // offer one item and hold it until accepted
  task automatic push_item(input tcw_item_t it);
    if ($urandom_range(99) == 0 && idle_pct != 0) begin
      // hold off until every awaited result is back
      in_valid <= 1'b0;
      do @(posedge clk); while (sb.pending() != 0);
    end else if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid   <= 1'b1;
    action     <= it.action;
    char_code  <= it.char_code;
    target_row <= it.target_row;
    target_col <= it.target_col;
    new_attr   <= it.new_attr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // register write, only with the block drained and idle
  task automatic write_default(input logic [7:0] attr);
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0 || !in_ready);
    cfg_we    <= 1'b1;
    cfg_wdata <= attr;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_default(attr);
  endtask

  // random phase: scattered items plus the odd long run of text to force wraps
  task automatic run_phase(input int n_items, input int idle, input int stall,
                           input int lf_pct, input logic [7:0] dflt);
    tcw_item_t it;
    int text_left;
    text_left = 0;
    write_default(dflt);
    idle_pct  = idle;
    stall_pct = stall;
    for (int k = 0; k < n_items; k++) begin
      if (text_left == 0 && $urandom_range(199) == 0) text_left = $urandom_range(100, 40);
      it = random_item(lf_pct);
      if (text_left > 0) begin
        text_left--;
        it.action    = ACT_PUT_CURSOR;
        it.char_code = ($urandom_range(9) == 0) ? CH_TAB : 8'($urandom_range(8'h7E, 8'h20));
      end
      push_item(it);
    end
  endtask

  initial begin
    sb         = new();
    rst        = 1'b1;
    in_valid   = 1'b0;
    action     = ACT_PUT_CURSOR;
    char_code  = '0;
    target_row = '0;
    target_col = '0;
    new_attr   = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed: until the first clear only cells written here are read back
    push_item(mk(ACT_PUT_CURSOR, 8'h00, 5'd0, 7'd0, 8'h00));    // char code low extreme
    push_item(mk(ACT_PUT_CURSOR, 8'hFF, 5'd31, 7'd127, 8'hFF)); // char code high extreme
    push_item(mk(ACT_READ, 8'h00, 5'd0, 7'd0, 8'h00));
    push_item(mk(ACT_READ, 8'hFF, 5'd0, 7'd1, 8'hFF));
    push_item(mk(ACT_PUT_AT, 8'h41, 5'(ROWS - 1), 7'(COLS - 1), 8'h00)); // bottom-right
    push_item(mk(ACT_READ, 8'h00, 5'(ROWS - 1), 7'(COLS - 1), 8'h00));
    push_item(mk(ACT_PUT_AT, 8'h42, 5'(ROWS), 7'd0, 8'h00));    // row just off screen
    push_item(mk(ACT_PUT_AT, 8'h43, 5'd31, 7'd127, 8'h00));     // both fields maxed
    push_item(mk(ACT_PUT_AT, 8'h44, 5'd0, 7'(COLS), 8'h00));    // column just off screen
    push_item(mk(ACT_READ, 8'h00, 5'd31, 7'd127, 8'h00));
    push_item(mk(ACT_READ, 8'h00, 5'(ROWS), 7'(COLS - 1), 8'h00));
    push_item(mk(ACT_READ, 8'h00, 5'(ROWS - 1), 7'(COLS), 8'h00));
    push_item(mk(ACT_SET_ATTR, 8'h00, 5'd0, 7'd0, 8'hFF));
    push_item(mk(ACT_PUT_CURSOR, 8'h78, 5'd0, 7'd0, 8'h00));
    push_item(mk(ACT_SET_ATTR, 8'h00, 5'd0, 7'd0, 8'h00));
    push_item(mk(ACT_CLEAR, 8'h00, 5'd0, 7'd0, 8'h00));         // also restores attribute
    push_item(mk(ACT_PUT_CURSOR, CH_TAB, 5'd0, 7'd0, 8'h00));   // full tab from column 0
    push_item(mk(ACT_PUT_CURSOR, 8'h61, 5'd0, 7'd0, 8'h00));
    push_item(mk(ACT_PUT_CURSOR, CH_TAB, 5'd0, 7'd0, 8'h00));   // partial tab
    push_item(mk(ACT_PUT_CURSOR, CH_CR, 5'd0, 7'd0, 8'h00));
    push_item(mk(ACT_PUT_CURSOR, CH_LF, 5'd0, 7'd0, 8'h00));
    push_item(mk(ACT_READ, 8'h00, 5'd0, 7'd4, 8'h00));
    push_item(mk(ACT_READ, 8'h00, 5'd0, 7'd7, 8'h00));
    push_item(mk(ACT_SPARE_LO, 8'h5A, 5'd3, 7'd9, 8'hA5));      // ignored action codes
    push_item(mk(ACT_SPARE_HI, 8'hA5, 5'd31, 7'd127, 8'h5A));

    // random phases: attribute extremes first, idling patterns rotate
    run_phase(245, 0, 0, 25, 8'h00);
    run_phase(245, 77, 0, 10, 8'hFF);
    run_phase(245, 0, 77, 30, 8'h5A);
    run_phase(245, 6, 6, 15, 8'($urandom));
    run_phase(245, 0, 0, 40, 8'($urandom));

    // drain, then give a trailing sweep time to show any stray result
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("text_console_writer_unit: match");
    end else begin
      $display("text_console_writer_unit: mismatch");
    end
    $finish;
  end

endmodule
